FILE: rtl/cbq_pkg.sv
package cbq_pkg;

    localparam int DATA_W  = 32;
    localparam int COEF_W  = 24;
    localparam int FRAC    = 20;
    localparam int ACC_W   = 60;
    localparam int DIGITS  = COEF_W / 2;
    localparam int DIG_W   = $clog2(DIGITS);
    localparam int CVT_W   = 48;

    typedef struct packed {
        logic acc_init;
        logic op_load;
        logic step;
    } t_mac_ctl;

    function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-FRAC-1:0] q;
        q = acc[ACC_W-1:FRAC];
        if (q[ACC_W-FRAC-1:DATA_W-1] == '0 || q[ACC_W-FRAC-1:DATA_W-1] == '1) begin
            return q[DATA_W-1:0];
        end
        return q[ACC_W-FRAC-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

FILE: rtl/cbq_mac.sv
module cbq_mac
    import cbq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [ACC_W-1:0]  i_acc_init,
    input  logic signed [DATA_W-1:0] i_data,
    input  logic signed [COEF_W-1:0] i_coef,
    output logic signed [ACC_W-1:0]  o_acc,
    output logic                     o_last
);

    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_md;
    logic signed [ACC_W-1:0]  r_md3;
    logic        [COEF_W-1:0] r_coef;
    logic        [DIG_W-1:0]  r_dig;
    logic signed [ACC_W-1:0]  md_ext;
    logic signed [ACC_W-1:0]  pp;
    logic                     top;

    assign md_ext = ACC_W'(i_data);
    assign top    = (r_dig == DIG_W'(DIGITS - 1));

    // radix-4 digit of the coefficient, top digit carries the sign weight
    always_comb begin
        pp = '0;
        if (top) begin
            case (r_coef[1:0])
                2'b01:   pp = r_md;
                2'b10:   pp = -(r_md <<< 1);
                2'b11:   pp = -r_md;
                default: pp = '0;
            endcase
        end else begin
            case (r_coef[1:0])
                2'b01:   pp = r_md;
                2'b10:   pp = r_md <<< 1;
                2'b11:   pp = r_md3;
                default: pp = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dig <= '0;
        end else if (i_ctl.op_load) begin
            r_dig <= '0;
        end else if (i_ctl.step) begin
            r_dig <= top ? '0 : r_dig + DIG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_init) begin
            r_acc <= i_acc_init;
        end else if (i_ctl.step) begin
            r_acc <= r_acc + pp;
        end
        if (i_ctl.op_load) begin
            r_md   <= md_ext;
            r_md3  <= md_ext + (md_ext <<< 1);
            r_coef <= i_coef;
        end else if (i_ctl.step) begin
            r_md   <= r_md <<< 2;
            r_md3  <= r_md3 <<< 2;
            r_coef <= r_coef >> 2;
        end
    end

    assign o_acc  = r_acc;
    assign o_last = top;

endmodule

FILE: rtl/cascaded_biquad_lowpass.sv
// Each section runs five 24x32 products through one radix-4 digit-serial MAC, one
// coefficient digit per step, with an operand load step before each product and a
// result step after it. A new sample is taken only in idle, after the last result
// has entered the output register; zero sections skip the MAC. Synchronous active-low
// reset clears control and delay words and presets unity gain with two sections.
module cascaded_biquad_lowpass
    import cbq_pkg::*;
#(
    parameter int MAX_SECTIONS = 4,
    parameter int SAMPLE_WIDTH = 16,
    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [TDATA_W-1:0]       s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [TDATA_W-1:0]       m_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample_out
    input  logic                     i_cfg_wen,
    input  logic [2:0]               i_cfg_index,
    input  logic [COEF_W-1:0]        i_cfg_wdata
);

    localparam int SH_UP   = (SAMPLE_WIDTH <= FRAC + 1) ? (FRAC + 1 - SAMPLE_WIDTH) : 0;
    localparam int SH_DN   = (SAMPLE_WIDTH > FRAC + 1) ? (SAMPLE_WIDTH - FRAC - 1) : 0;
    localparam int SEC_IW  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W   = $clog2(MAX_SECTIONS + 1);
    localparam logic signed [CVT_W-1:0] RND_IN  = (CVT_W'(1) << SH_DN) >> 1;
    localparam logic signed [CVT_W-1:0] RND_OUT = (CVT_W'(1) << SH_UP) >> 1;
    localparam logic signed [CVT_W-1:0] OUT_HI  = (CVT_W'(1) << (SAMPLE_WIDTH - 1)) - CVT_W'(1);
    localparam logic signed [CVT_W-1:0] OUT_LO  = -(CVT_W'(1) << (SAMPLE_WIDTH - 1));

    localparam logic [2:0] REG_FB1  = 3'd0;
    localparam logic [2:0] REG_FB2  = 3'd1;
    localparam logic [2:0] REG_FZ   = 3'd2;
    localparam logic [2:0] REG_F1   = 3'd3;
    localparam logic [2:0] REG_F2   = 3'd4;
    localparam logic [2:0] REG_NSEC = 3'd5;

    localparam logic [2:0] P_FB1 = 3'd0;
    localparam logic [2:0] P_FB2 = 3'd1;
    localparam logic [2:0] P_FZ  = 3'd2;
    localparam logic [2:0] P_F1  = 3'd3;
    localparam logic [2:0] P_F2  = 3'd4;

    typedef enum logic [2:0] {S_IDLE, S_START, S_LOAD, S_MUL, S_NEXT, S_FIN} t_state;

    t_state                    r_state;
    logic signed [COEF_W-1:0]  r_fb1, r_fb2, r_fz, r_f1, r_f2;
    logic        [2:0]         r_sections;
    logic        [CNT_W-1:0]   r_nsec;
    logic        [SEC_IW-1:0]  r_sec;
    logic        [2:0]         r_prod;
    logic signed [DATA_W-1:0]  r_y, r_s1, r_s2, r_w;
    logic signed [DATA_W-1:0]  r_recent [MAX_SECTIONS];
    logic signed [DATA_W-1:0]  r_older  [MAX_SECTIONS];
    logic                      r_ovalid;
    logic [SAMPLE_WIDTH-1:0]   r_odata;

    t_mac_ctl                  mac_ctl;
    logic signed [ACC_W-1:0]   acc_init;
    logic signed [DATA_W-1:0]  mac_data;
    logic signed [COEF_W-1:0]  mac_coef;
    logic signed [ACC_W-1:0]   mac_acc;
    logic                      mac_last;
    logic signed [DATA_W-1:0]  sat_res;

    logic signed [SAMPLE_WIDTH-1:0] x_in;
    logic signed [CVT_W-1:0]   cvt_in;
    logic signed [CVT_W-1:0]   cvt_out;
    logic [SAMPLE_WIDTH-1:0]   out_sat;
    logic [CNT_W-1:0]          n_clamp;
    logic                      sec_last;

    assign x_in    = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign cvt_in  = ((CVT_W'(x_in) <<< SH_UP) + RND_IN) >>> SH_DN;
    assign cvt_out = ((CVT_W'(r_y) <<< SH_DN) + RND_OUT) >>> SH_UP;
    assign n_clamp = (32'(r_sections) > MAX_SECTIONS) ? CNT_W'(MAX_SECTIONS)
                                                       : CNT_W'(r_sections);
    assign sec_last = ((CNT_W'(r_sec) + CNT_W'(1)) == r_nsec);
    assign sat_res  = sat_acc(mac_acc);

    always_comb begin
        if (cvt_out > OUT_HI) begin
            out_sat = OUT_HI[SAMPLE_WIDTH-1:0];
        end else if (cvt_out < OUT_LO) begin
            out_sat = OUT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            out_sat = cvt_out[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb begin
        unique case (r_prod)
            P_FB1:   begin mac_data = r_s1; mac_coef = r_fb1; end
            P_FB2:   begin mac_data = r_s2; mac_coef = r_fb2; end
            P_FZ:    begin mac_data = r_w;  mac_coef = r_fz;  end
            P_F1:    begin mac_data = r_s1; mac_coef = r_f1;  end
            default: begin mac_data = r_s2; mac_coef = r_f2;  end
        endcase
    end

    // accumulator preset: section input in Q12.20 plus the rounding half, or rounding half only
    always_comb begin
        mac_ctl.op_load  = (r_state == S_LOAD);
        mac_ctl.step     = (r_state == S_MUL);
        mac_ctl.acc_init = (r_state == S_START) || (r_state == S_NEXT && r_prod == P_FB2);
        if (r_state == S_START) begin
            acc_init = {{(ACC_W - DATA_W - FRAC){r_y[DATA_W-1]}}, r_y, 1'b1, {(FRAC-1){1'b0}}};
        end else begin
            acc_init = ACC_W'(1) <<< (FRAC - 1);
        end
    end

    cbq_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mac_ctl),
        .i_acc_init (acc_init),
        .i_data     (mac_data),
        .i_coef     (mac_coef),
        .o_acc      (mac_acc),
        .o_last     (mac_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb1      <= '0;
            r_fb2      <= '0;
            r_fz       <= COEF_W'(1 << FRAC);
            r_f1       <= '0;
            r_f2       <= '0;
            r_sections <= 3'd2;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                REG_FB1:  r_fb1      <= i_cfg_wdata;
                REG_FB2:  r_fb2      <= i_cfg_wdata;
                REG_FZ:   r_fz       <= i_cfg_wdata;
                REG_F1:   r_f1       <= i_cfg_wdata;
                REG_F2:   r_f2       <= i_cfg_wdata;
                REG_NSEC: r_sections <= i_cfg_wdata[2:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sec    <= '0;
            r_nsec   <= '0;
            r_prod   <= P_FB1;
            r_ovalid <= 1'b0;
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                r_recent[i] <= '0;
                r_older[i]  <= '0;
            end
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_y    <= cvt_in[DATA_W-1:0];
                        r_sec  <= '0;
                        r_nsec <= n_clamp;
                        r_state <= (n_clamp == '0) ? S_FIN : S_START;
                    end
                end
                S_START: begin
                    r_s1    <= r_recent[r_sec];
                    r_s2    <= r_older[r_sec];
                    r_prod  <= P_FB1;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (mac_last) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_prod == P_FB2) begin
                        r_w     <= sat_res;
                        r_prod  <= P_FZ;
                        r_state <= S_LOAD;
                    end else if (r_prod == P_F2) begin
                        r_y             <= sat_res;
                        r_recent[r_sec] <= r_w;
                        r_older[r_sec]  <= r_s1;
                        if (sec_last) begin
                            r_state <= S_FIN;
                        end else begin
                            r_sec   <= r_sec + SEC_IW'(1);
                            r_state <= S_START;
                        end
                    end else begin
                        r_prod  <= r_prod + 3'd1;
                        r_state <= S_LOAD;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= out_sat;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = TDATA_W'(r_odata);

`ifndef SYNTHESIS
    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START || r_state == S_LOAD || r_state == S_MUL || r_state == S_NEXT)
        |-> (CNT_W'(r_sec) < r_nsec))
        else $error("section index beyond active count");

    a_prod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prod <= P_F2))
        else $error("product index out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state != S_IDLE))
        else $error("block still idle after input transfer");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_FIN))
        else $error("output raised outside finish step");
`endif

endmodule

FILE: test/cascaded_biquad_lowpass_checker.sv
`timescale 1ns / 1ps

package cbq_test_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int SAMPLE_BUS_W = ((SAMPLE_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        REG_FEEDBACK_ONE = 3'd0,
        REG_FEEDBACK_TWO = 3'd1,
        REG_FORWARD_ZERO = 3'd2,
        REG_FORWARD_ONE  = 3'd3,
        REG_FORWARD_TWO  = 3'd4,
        REG_SECTIONS     = 3'd5,
        REG_SPARE_A      = 3'd6,
        REG_SPARE_B      = 3'd7
    } t_cfg_reg;

endpackage

module cascaded_biquad_lowpass_checker
    import cbq_pkg::*;
    import cbq_test_pkg::*;
#(
    parameter int STAGES = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [SAMPLE_BUS_W-1:0] s_axis_tdata,   // [15:0] sample_in
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [SAMPLE_BUS_W-1:0] m_axis_tdata,   // [15:0] sample_out
    input  logic                    i_cfg_wen,
    input  logic [2:0]              i_cfg_index,
    input  logic [COEF_W-1:0]       i_cfg_wdata,
    output int                      o_errors,
    output int                      o_outstanding,
    output int                      o_checked
);

    localparam longint WORD_MAX     = 64'sd2147483647;
    localparam longint WORD_MIN     = -64'sd2147483648;
    localparam longint HALF_LSB     = 64'sd1 <<< (FRAC - 1);
    localparam longint SAMPLE_MAX   = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN   = -(64'sd1 <<< (SAMPLE_W - 1));
    localparam int     REPORT_LIMIT = 40;

    longint coef_fb1, coef_fb2, coef_ff0, coef_ff1, coef_ff2;
    int unsigned stages_on;
    longint section_w1 [STAGES];
    longint section_w2 [STAGES];

    logic [SAMPLE_W-1:0] expected_samples [$];
    int mismatches;
    int compared;

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    function automatic longint round_q20(input longint v);
        return (v + HALF_LSB) >>> FRAC;
    endfunction

    // Runs one sample through the active sections and advances their delay words.
    function automatic logic [SAMPLE_W-1:0] filter_sample(input logic [SAMPLE_W-1:0] x);
        longint v, w, s1, s2;
        int n;
        v = longint'($signed(x)) * (64'sd1 <<< (FRAC - (SAMPLE_W - 1)));
        n = (stages_on > STAGES) ? STAGES : int'(stages_on);
        for (int i = 0; i < n; i++) begin
            s1 = section_w1[i];
            s2 = section_w2[i];
            w = clamp_word(v + round_q20(coef_fb1 * s1 + coef_fb2 * s2));
            v = clamp_word(round_q20(coef_ff0 * w + coef_ff1 * s1 + coef_ff2 * s2));
            section_w2[i] = s1;
            section_w1[i] = w;
        end
        v = (v + (64'sd1 <<< (FRAC - SAMPLE_W))) >>> (FRAC - (SAMPLE_W - 1));
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        return v[SAMPLE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [SAMPLE_W-1:0] want;
        logic [SAMPLE_W-1:0] got;
        if (!i_rst_n) begin
            coef_fb1 = 0;
            coef_fb2 = 0;
            coef_ff0 = 64'sd1 <<< FRAC;
            coef_ff1 = 0;
            coef_ff2 = 0;
            stages_on = 2;
            for (int i = 0; i < STAGES; i++) begin
                section_w1[i] = 0;
                section_w2[i] = 0;
            end
            expected_samples.delete();
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_index)
                    REG_FEEDBACK_ONE: coef_fb1 = longint'($signed(i_cfg_wdata));
                    REG_FEEDBACK_TWO: coef_fb2 = longint'($signed(i_cfg_wdata));
                    REG_FORWARD_ZERO: coef_ff0 = longint'($signed(i_cfg_wdata));
                    REG_FORWARD_ONE:  coef_ff1 = longint'($signed(i_cfg_wdata));
                    REG_FORWARD_TWO:  coef_ff2 = longint'($signed(i_cfg_wdata));
                    REG_SECTIONS:     stages_on = i_cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_samples.push_back(filter_sample(s_axis_tdata[SAMPLE_W-1:0]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[SAMPLE_W-1:0];
                if (expected_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $error("sample_out: expected none, actual %0d", $signed(got));
                    end
                end else begin
                    want = expected_samples.pop_front();
                    compared++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $error("sample_out: expected %0d, actual %0d",
                                   $signed(want), $signed(got));
                        end
                    end
                end
            end
        end
        o_errors      <= mismatches;
        o_outstanding <= expected_samples.size();
        o_checked     <= compared;
    end

endmodule

FILE: test/cascaded_biquad_lowpass_test.sv
`timescale 1ns / 1ps

module cascaded_biquad_lowpass_test;
    import cbq_pkg::*;
    import cbq_test_pkg::*;

    localparam int STAGES         = 4;
    localparam int STALL_LIMIT    = 20000;
    localparam int LONG_HOLD      = 2000;
    localparam int TARGET_SAMPLES = 1150;
    localparam int DRAIN_CYCLES   = 300;

    localparam int COEF_MAX = 8388607;
    localparam int COEF_MIN = -8388608;
    localparam int UNITY    = 1048576;

    // second-order Butterworth low-pass, fc = 0.1 fs and 0.25 fs, feedback signs folded in
    localparam int LP10_FB1 = 1198501;
    localparam int LP10_FB2 = -432852;
    localparam int LP10_FF0 = 70732;
    localparam int LP10_FF1 = 141464;
    localparam int LP25_FB1 = 0;
    localparam int LP25_FB2 = -179936;
    localparam int LP25_FF0 = 307130;
    localparam int LP25_FF1 = 614260;

    logic                    i_clk;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [SAMPLE_BUS_W-1:0] s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [SAMPLE_BUS_W-1:0] m_axis_tdata;
    logic                    i_cfg_wen     = 1'b0;
    logic [2:0]              i_cfg_index   = REG_FEEDBACK_ONE;
    logic [COEF_W-1:0]       i_cfg_wdata   = '0;

    int fail_count;
    int pending_results;
    int compared_results;

    int  sent;
    int  settings;
    bit  steady;
    bit  long_hold_req;
    logic [SAMPLE_W-1:0] last_sample;

    cascaded_biquad_lowpass #(
        .MAX_SECTIONS (STAGES),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    cascaded_biquad_lowpass_checker #(
        .STAGES (STAGES)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_errors      (fail_count),
        .o_outstanding (pending_results),
        .o_checked     (compared_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 24);
        return $urandom_range(60, 300);
    endfunction

    function automatic int random_coef();
        return int'($urandom_range(0, 16777215)) + COEF_MIN;
    endfunction

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [COEF_W-1:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic load_setting(input int fb1, input int fb2, input int ff0,
                                input int ff1, input int ff2, input int stages,
                                input bit spare);
        wait_idle();
        write_reg(REG_FEEDBACK_ONE, fb1[COEF_W-1:0]);
        write_reg(REG_FEEDBACK_TWO, fb2[COEF_W-1:0]);
        write_reg(REG_FORWARD_ZERO, ff0[COEF_W-1:0]);
        write_reg(REG_FORWARD_ONE,  ff1[COEF_W-1:0]);
        write_reg(REG_FORWARD_TWO,  ff2[COEF_W-1:0]);
        write_reg(REG_SECTIONS,     stages[COEF_W-1:0]);
        if (spare) begin
            write_reg(REG_SPARE_A, COEF_W'($urandom()));
            write_reg(REG_SPARE_B, COEF_W'($urandom()));
        end
        i_cfg_wen <= 1'b0;
        settings++;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] x);
        s_axis_tdata  <= SAMPLE_BUS_W'(x);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        last_sample = x;
        sent++;
    endtask

    task automatic pause_after();
        int n;
        n = steady ? 0 : gap_length();
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] next_sample();
        int r;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: if (r < 12) return 16'h7fff;
            1: if (r < 12) return 16'h8000;
            default: ;
        endcase
        if (r < 45) return last_sample;
        return SAMPLE_W'($urandom());
    endfunction

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                n = steady ? 0 : gap_length();
                if (n > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("cascaded_biquad_lowpass_test: errors");
        $finish;
    end

    initial begin
        int phase;
        int len;
        int stages;
        int r;
        int fb1, fb2, ff0, ff1, ff2;

        sent = 0;
        settings = 0;
        steady = 1'b0;
        long_hold_req = 1'b0;
        last_sample = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: two unity sections
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h0001);

        // bypass with extreme coefficients
        load_setting(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN, 0, 1'b0);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h1234);

        // all sections, driven into saturation
        load_setting(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN, 4, 1'b0);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h8000);

        // count above the section limit
        load_setting(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 7, 1'b0);
        send_sample(16'h8000);
        send_sample(16'h7fff);

        // one section only; later sections must keep their words
        load_setting(LP10_FB1, LP10_FB2, LP10_FF0, LP10_FF1, LP10_FF0, 1, 1'b0);
        send_sample(16'h4000);
        send_sample(16'h4000);
        send_sample(16'hc000);

        // writes to unmapped indexes are dropped
        load_setting(LP10_FB1, LP10_FB2, LP10_FF0, LP10_FF1, LP10_FF0, 4, 1'b1);
        send_sample(16'h2000);
        send_sample(16'h0000);
        send_sample(16'he000);

        load_setting(LP25_FB1, LP25_FB2, LP25_FF0, LP25_FF1, LP25_FF0, 5, 1'b0);
        send_sample(16'h7fff);
        send_sample(16'h7fff);

        phase = 0;
        while (sent < TARGET_SAMPLES) begin
            r = $urandom_range(0, 99);
            if (r < 8) stages = 0;
            else if (r < 16) stages = $urandom_range(5, 7);
            else stages = $urandom_range(1, STAGES);
            case ($urandom_range(0, 3))
                0: begin
                    fb1 = LP10_FB1; fb2 = LP10_FB2;
                    ff0 = LP10_FF0; ff1 = LP10_FF1; ff2 = LP10_FF0;
                end
                1: begin
                    fb1 = LP25_FB1; fb2 = LP25_FB2;
                    ff0 = LP25_FF0; ff1 = LP25_FF1; ff2 = LP25_FF0;
                end
                2: begin
                    fb1 = int'($urandom_range(0, 2 * UNITY)) - UNITY;
                    fb2 = -int'($urandom_range(0, UNITY - 1));
                    ff0 = int'($urandom_range(0, UNITY)) - UNITY / 2;
                    ff1 = int'($urandom_range(0, UNITY)) - UNITY / 2;
                    ff2 = int'($urandom_range(0, UNITY)) - UNITY / 2;
                end
                default: begin
                    fb1 = random_coef(); fb2 = random_coef();
                    ff0 = random_coef(); ff1 = random_coef(); ff2 = random_coef();
                end
            endcase
            load_setting(fb1, fb2, ff0, ff1, ff2, stages, $urandom_range(0, 3) == 0);
            steady = ($urandom_range(0, 4) == 0);
            if (phase == 2) begin
                steady = 1'b0;
                long_hold_req = 1'b1;
            end
            len = $urandom_range(40, 120);
            repeat (len) begin
                send_sample(next_sample());
                pause_after();
            end
            phase++;
        end

        steady = 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d samples over %0d filter settings: bypass, 1 to 7 sections, extreme",
                 sent, settings);
        $display("and low-pass coefficients, saturation, unmapped writes; %0d results compared",
                 compared_results);
        if (fail_count == 0 && pending_results == 0) begin
            $display("cascaded_biquad_lowpass_test: clean");
        end else begin
            $display("cascaded_biquad_lowpass_test: errors");
        end
        $finish;
    end

endmodule
